// ===== rtl/gic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg
// Shared widths and codes of the grid index / coordinate converter.
// ----------------------------------------------------------------------------
package gic_pkg;

  localparam int INDEX_BITS_DEF = 24;
  localparam int COORD_BITS_DEF = 16;

  localparam int FUNC_W     = 3;
  localparam int CNT_W      = 13;  // coarse cell counts
  localparam int FAC_W      = 5;   // fine cells per coarse cell
  localparam int MEM_W      = 16;  // members per coarse cell
  localparam int EX_W       = CNT_W + FAC_W;   // fine row length
  localparam int PL_W       = 2 * EX_W;        // fine plane size
  localparam int CPL_W      = 2 * CNT_W;       // coarse plane size
  localparam int DIV_W      = PL_W;            // widest divisor
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [FUNC_W-1:0]    func_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam func_t FN_FINE_SPLIT   = 3'd0;
  localparam func_t FN_FINE_JOIN    = 3'd1;
  localparam func_t FN_COARSE_SPLIT = 3'd2;
  localparam func_t FN_COARSE_JOIN  = 3'd3;
  localparam func_t FN_FINE2COARSE  = 3'd4;
  localparam func_t FN_MEMBER       = 3'd5;

  localparam cfg_idx_t REG_COARSE_X = 3'd0;
  localparam cfg_idx_t REG_COARSE_Y = 3'd1;
  localparam cfg_idx_t REG_FINE_X   = 3'd2;
  localparam cfg_idx_t REG_FINE_Y   = 3'd3;
  localparam cfg_idx_t REG_FINE_C   = 3'd4;
  localparam cfg_idx_t REG_MEMBERS  = 3'd5;

endpackage

// ===== rtl/grid_index_coordinate_converter.sv =====
`timescale 1ns / 1ps
// Path: an accepted word passes the product stages, division chain A, division
//   chain B and the output register before out_valid.
// Throughput: one word per cycle while in_stall is low (the skid slot is empty);
//   the two division cell rows, one quotient bit per cell, set the depth, not the rate.
// Reset: synchronous active-low rst_n empties the pipeline and sets every
//   configuration register to 1.
// ----------------------------------------------------------------------------
// grid_index_coordinate_converter
// Row-major 3D index <-> coordinate conversion on a coarse and a fine grid.
// ----------------------------------------------------------------------------
module grid_index_coordinate_converter #(
  parameter int INDEX_BITS = gic_pkg::INDEX_BITS_DEF,
  parameter int COORD_BITS = gic_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gic_pkg::FUNC_W-1:0]   in_func,
  input  logic [INDEX_BITS-1:0]        in_linear_index,
  input  logic [COORD_BITS-1:0]        in_coord_x,
  input  logic [COORD_BITS-1:0]        in_coord_y,
  input  logic [COORD_BITS-1:0]        in_coord_c,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [INDEX_BITS-1:0]        out_result_index,
  output logic [COORD_BITS-1:0]        out_result_x,
  output logic [COORD_BITS-1:0]        out_result_y,
  output logic [COORD_BITS-1:0]        out_result_c,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gic_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gic_pkg::*;

  localparam int DW   = (INDEX_BITS > COORD_BITS) ? INDEX_BITS : COORD_BITS;
  localparam int IB   = INDEX_BITS;
  localparam int CB   = COORD_BITS;
  localparam int SW_A = FUNC_W + IB + EX_W;
  localparam int SW_B = FUNC_W + IB + 3 * DW;

  // configuration
  logic [CNT_W-1:0] nx_r, ny_r;
  logic [FAC_W-1:0] fx_r, fy_r, fc_r;
  logic [MEM_W-1:0] mp_r;
  logic [CNT_W-1:0] nx, ny;
  logic [FAC_W-1:0] fx, fy, fc;
  logic [MEM_W-1:0] mp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= CNT_W'(1);
      ny_r <= CNT_W'(1);
      fx_r <= FAC_W'(1);
      fy_r <= FAC_W'(1);
      fc_r <= FAC_W'(1);
      mp_r <= MEM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COARSE_X: nx_r <= cfg_data[CNT_W-1:0];
        REG_COARSE_Y: ny_r <= cfg_data[CNT_W-1:0];
        REG_FINE_X:   fx_r <= cfg_data[FAC_W-1:0];
        REG_FINE_Y:   fy_r <= cfg_data[FAC_W-1:0];
        REG_FINE_C:   fc_r <= cfg_data[FAC_W-1:0];
        REG_MEMBERS:  mp_r <= cfg_data[MEM_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero count acts as one
  assign nx = (nx_r == '0) ? CNT_W'(1) : nx_r;
  assign ny = (ny_r == '0) ? CNT_W'(1) : ny_r;
  assign fx = (fx_r == '0) ? FAC_W'(1) : fx_r;
  assign fy = (fy_r == '0) ? FAC_W'(1) : fy_r;
  assign fc = (fc_r == '0) ? FAC_W'(1) : fc_r;
  assign mp = (mp_r == '0) ? MEM_W'(1) : mp_r;

  // pipeline advance: hold the stages and division chains while the skid slot is occupied
  logic en;
  logic skid_v_r, out_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage 0: capture word, first products
  logic          s0_v_r;
  func_t         s0_func_r;
  logic [IB-1:0] s0_idx_r;
  logic [CB-1:0] s0_x_r, s0_y_r, s0_c_r;
  logic [EX_W-1:0] s0_fex_r, s0_fey_r;
  logic [CPL_W-1:0] s0_cpl_r;

  // stage 1: fine plane size
  logic          s1_v_r;
  func_t         s1_func_r;
  logic [IB-1:0] s1_idx_r;
  logic [CB-1:0] s1_x_r, s1_y_r, s1_c_r;
  logic [EX_W-1:0] s1_fex_r;
  logic [CPL_W-1:0] s1_cpl_r;
  logic [PL_W-1:0]  s1_fpl_r;

  // stage 2: join products, selected grid
  logic          s2_v_r;
  func_t         s2_func_r;
  logic [IB-1:0] s2_idx_r;
  logic [CB-1:0] s2_x_r, s2_y_r, s2_c_r;
  logic [EX_W-1:0] s2_ex_r;
  logic [PL_W-1:0] s2_pl_r;
  logic [IB-1:0]   s2_pc_r, s2_py_r;

  logic            s1_fine;
  logic [PL_W-1:0] s1_pl_sel;
  logic [EX_W-1:0] s1_ex_sel;

  assign s1_fine   = (s1_func_r == FN_FINE_SPLIT) || (s1_func_r == FN_FINE_JOIN);
  assign s1_pl_sel = s1_fine ? s1_fpl_r : PL_W'(s1_cpl_r);
  assign s1_ex_sel = s1_fine ? s1_fex_r : EX_W'(nx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_func_r <= in_func;
      s0_idx_r  <= in_linear_index;
      s0_x_r    <= in_coord_x;
      s0_y_r    <= in_coord_y;
      s0_c_r    <= in_coord_c;
      s0_fex_r  <= EX_W'(nx) * EX_W'(fx);
      s0_fey_r  <= EX_W'(ny) * EX_W'(fy);
      s0_cpl_r  <= CPL_W'(nx) * CPL_W'(ny);

      s1_func_r <= s0_func_r;
      s1_idx_r  <= s0_idx_r;
      s1_x_r    <= s0_x_r;
      s1_y_r    <= s0_y_r;
      s1_c_r    <= s0_c_r;
      s1_fex_r  <= s0_fex_r;
      s1_cpl_r  <= s0_cpl_r;
      s1_fpl_r  <= PL_W'(s0_fex_r) * PL_W'(s0_fey_r);

      s2_func_r <= s1_func_r;
      s2_idx_r  <= s1_idx_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_c_r    <= s1_c_r;
      s2_ex_r   <= s1_ex_sel;
      s2_pl_r   <= s1_pl_sel;
      // index wraps at IB bits, so the factors can be cut to IB bits first
      s2_pc_r   <= IB'(s1_c_r) * IB'(s1_pl_sel);
      s2_py_r   <= IB'(s1_y_r) * IB'(s1_ex_sel);
    end
  end

  // chain A: idx / plane, member division, or three per-axis divisions
  logic [IB-1:0]       a_join;
  logic [3*DW-1:0]     a_dvd;
  logic [3*DIV_W-1:0]  a_div;
  logic [SW_A-1:0]     a_side;

  assign a_join = s2_pc_r + s2_py_r + IB'(s2_x_r);
  assign a_side = {s2_func_r, a_join, s2_ex_r};

  always_comb begin
    a_dvd = '0;
    a_div = {3{DIV_W'(1)}};
    case (s2_func_r)
      FN_FINE_SPLIT, FN_COARSE_SPLIT: begin
        a_dvd[0 +: DW]    = DW'(s2_idx_r);
        a_div[0 +: DIV_W] = s2_pl_r;
      end
      FN_MEMBER: begin
        a_dvd[0 +: DW]    = DW'(s2_idx_r);
        a_div[0 +: DIV_W] = DIV_W'(mp);
      end
      FN_FINE2COARSE: begin
        a_dvd[0 +: DW]          = DW'(s2_x_r);
        a_dvd[DW +: DW]         = DW'(s2_y_r);
        a_dvd[2*DW +: DW]       = DW'(s2_c_r);
        a_div[0 +: DIV_W]       = DIV_W'(fx);
        a_div[DIV_W +: DIV_W]   = DIV_W'(fy);
        a_div[2*DIV_W +: DIV_W] = DIV_W'(fc);
      end
      default: ;
    endcase
  end

  logic            ao_v;
  logic [3*DW-1:0] ao_rem, ao_quo;
  logic [SW_A-1:0] ao_side;

  gic_div_chain #(
    .LANES(3), .DW(DW), .VW(DIV_W), .SW(SW_A)
  ) u_chain_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s2_v_r),
    .in_dvd   (a_dvd),
    .in_div   (a_div),
    .in_side  (a_side),
    .out_valid(ao_v),
    .out_rem  (ao_rem),
    .out_quo  (ao_quo),
    .out_side (ao_side)
  );

  // chain B: plane remainder / row length
  func_t           ao_func;
  logic [IB-1:0]   ao_join;
  logic [EX_W-1:0] ao_ex;
  logic            ao_split;
  logic [DW-1:0]   b_dvd;
  logic [DIV_W-1:0] b_div;
  logic [SW_B-1:0] b_side;

  assign {ao_func, ao_join, ao_ex} = ao_side;
  assign ao_split = (ao_func == FN_FINE_SPLIT) || (ao_func == FN_COARSE_SPLIT);
  assign b_dvd    = ao_split ? ao_rem[0 +: DW] : '0;
  assign b_div    = DIV_W'(ao_ex);
  assign b_side   = {ao_func, ao_join, ao_quo};

  logic            bo_v;
  logic [DW-1:0]   bo_rem, bo_quo;
  logic [SW_B-1:0] bo_side;

  gic_div_chain #(
    .LANES(1), .DW(DW), .VW(DIV_W), .SW(SW_B)
  ) u_chain_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (ao_v),
    .in_dvd   (b_dvd),
    .in_div   (b_div),
    .in_side  (b_side),
    .out_valid(bo_v),
    .out_rem  (bo_rem),
    .out_quo  (bo_quo),
    .out_side (bo_side)
  );

  // result formatting
  func_t           bo_func;
  logic [IB-1:0]   bo_join;
  logic [3*DW-1:0] bo_q;
  logic [IB-1:0]   p_idx;
  logic [CB-1:0]   p_x, p_y, p_c;

  assign {bo_func, bo_join, bo_q} = bo_side;

  always_comb begin
    p_idx = '0;
    p_x   = '0;
    p_y   = '0;
    p_c   = '0;
    case (bo_func)
      FN_FINE_SPLIT, FN_COARSE_SPLIT: begin
        p_x = CB'(bo_rem);
        p_y = CB'(bo_quo);
        p_c = CB'(bo_q[0 +: DW]);
      end
      FN_FINE_JOIN, FN_COARSE_JOIN: begin
        p_idx = bo_join;
      end
      FN_FINE2COARSE: begin
        p_x = CB'(bo_q[0 +: DW]);
        p_y = CB'(bo_q[DW +: DW]);
        p_c = CB'(bo_q[2*DW +: DW]);
      end
      FN_MEMBER: begin
        p_idx = IB'(bo_q[0 +: DW]);
      end
      default: ;
    endcase
  end

  // output register with one skid slot
  logic [IB-1:0] out_idx_r, skid_idx_r;
  logic [CB-1:0] out_x_r, out_y_r, out_c_r;
  logic [CB-1:0] skid_x_r, skid_y_r, skid_c_r;
  logic          out_hold;

  assign out_hold = out_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_hold) begin
      if (en && bo_v) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= bo_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_hold) begin
      if (en && bo_v) begin
        skid_idx_r <= p_idx;
        skid_x_r   <= p_x;
        skid_y_r   <= p_y;
        skid_c_r   <= p_c;
      end
    end else if (skid_v_r) begin
      out_idx_r <= skid_idx_r;
      out_x_r   <= skid_x_r;
      out_y_r   <= skid_y_r;
      out_c_r   <= skid_c_r;
    end else begin
      out_idx_r <= p_idx;
      out_x_r   <= p_x;
      out_y_r   <= p_y;
      out_c_r   <= p_c;
    end
  end

  assign out_valid        = out_v_r;
  assign out_result_index = out_idx_r;
  assign out_result_x     = out_x_r;
  assign out_result_y     = out_y_r;
  assign out_result_c     = out_c_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full while output register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid slot filled without a stalled output");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> (!skid_v_r && out_v_r))
    else $error("skid slot did not drain into output register");

endmodule

// ===== rtl/gic_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_div_cell
// One restoring-division step for LANES lanes: shift in one dividend bit,
// subtract when possible, shift in one quotient bit.
// ----------------------------------------------------------------------------
module gic_div_cell #(
  parameter int LANES = 1,
  parameter int DW    = 24,
  parameter int VW    = 36,
  parameter int SW    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [LANES*DW-1:0] in_rem,
  input  logic [LANES*DW-1:0] in_dvd,
  input  logic [LANES*DW-1:0] in_quo,
  input  logic [LANES*VW-1:0] in_div,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [LANES*DW-1:0] out_rem,
  output logic [LANES*DW-1:0] out_dvd,
  output logic [LANES*DW-1:0] out_quo,
  output logic [LANES*VW-1:0] out_div,
  output logic [SW-1:0]       out_side
);

  localparam int CW = (DW + 1 > VW) ? DW + 1 : VW;

  logic                valid_r;
  logic [LANES*DW-1:0] rem_r, rem_nxt;
  logic [LANES*DW-1:0] dvd_r, dvd_nxt;
  logic [LANES*DW-1:0] quo_r, quo_nxt;
  logic [LANES*VW-1:0] div_r;
  logic [SW-1:0]       side_r;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [CW-1:0] trial;
    logic [CW-1:0] dsr;
    logic          fits;
    assign trial = CW'({in_rem[l*DW +: DW], in_dvd[l*DW + DW - 1]});
    assign dsr   = CW'(in_div[l*VW +: VW]);
    assign fits  = (trial >= dsr);
    assign rem_nxt[l*DW +: DW] = fits ? DW'(trial - dsr) : DW'(trial);
    assign dvd_nxt[l*DW +: DW] = {in_dvd[l*DW +: DW-1], 1'b0};
    assign quo_nxt[l*DW +: DW] = {in_quo[l*DW +: DW-1], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      dvd_r  <= dvd_nxt;
      quo_r  <= quo_nxt;
      div_r  <= in_div;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_dvd   = dvd_r;
  assign out_quo   = quo_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

// ===== rtl/gic_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_div_chain
// Row of DW division cells; a word leaves with full quotient and remainder.
// ----------------------------------------------------------------------------
module gic_div_chain #(
  parameter int LANES = 1,
  parameter int DW    = 24,
  parameter int VW    = 36,
  parameter int SW    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [LANES*DW-1:0] in_dvd,
  input  logic [LANES*VW-1:0] in_div,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [LANES*DW-1:0] out_rem,
  output logic [LANES*DW-1:0] out_quo,
  output logic [SW-1:0]       out_side
);

  logic                v_w    [0:DW];
  logic [LANES*DW-1:0] rem_w  [0:DW];
  logic [LANES*DW-1:0] dvd_w  [0:DW];
  logic [LANES*DW-1:0] quo_w  [0:DW];
  logic [LANES*VW-1:0] div_w  [0:DW];
  logic [SW-1:0]       side_w [0:DW];

  assign v_w[0]    = in_valid;
  assign rem_w[0]  = '0;
  assign dvd_w[0]  = in_dvd;
  assign quo_w[0]  = '0;
  assign div_w[0]  = in_div;
  assign side_w[0] = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    gic_div_cell #(
      .LANES(LANES), .DW(DW), .VW(VW), .SW(SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_w[i]),
      .in_rem   (rem_w[i]),
      .in_dvd   (dvd_w[i]),
      .in_quo   (quo_w[i]),
      .in_div   (div_w[i]),
      .in_side  (side_w[i]),
      .out_valid(v_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_dvd  (dvd_w[i+1]),
      .out_quo  (quo_w[i+1]),
      .out_div  (div_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  assign out_valid = v_w[DW];
  assign out_rem   = rem_w[DW];
  assign out_quo   = quo_w[DW];
  assign out_side  = side_w[DW];

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid index / coordinate converter. Streams
// conversion words under several grid settings with random gaps and output
// stalls, and checks every result against an in-bench model of the grid math.
// ----------------------------------------------------------------------------
module tb_top;
  import gic_pkg::*;

  localparam int IW = INDEX_BITS_DEF;
  localparam int CW = COORD_BITS_DEF;
  localparam int LATENCY = 2 * IW + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_PHASE = 265;
  localparam func_t FN_SPARE_6 = 3'd6;
  localparam func_t FN_SPARE_7 = 3'd7;

  typedef struct packed {
    func_t         func;
    logic [IW-1:0] idx;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] c;
  } conv_word_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] c;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  func_t in_func = '0;
  logic [IW-1:0] in_linear_index = '0;
  logic [CW-1:0] in_coord_x = '0;
  logic [CW-1:0] in_coord_y = '0;
  logic [CW-1:0] in_coord_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IW-1:0] out_result_index;
  logic [CW-1:0] out_result_x;
  logic [CW-1:0] out_result_y;
  logic [CW-1:0] out_result_c;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  conv_word_t   pending_words[$];
  conv_result_t expected_results[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;

  // shadow copy of the grid registers
  logic [CNT_W-1:0] sh_cells_x = 1, sh_cells_y = 1;
  logic [FAC_W-1:0] sh_fine_x = 1, sh_fine_y = 1, sh_fine_c = 1;
  logic [MEM_W-1:0] sh_members = 1;

  grid_index_coordinate_converter dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned one_if_zero(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic conv_result_t convert_grid_word(conv_word_t w);
    longint unsigned nx, ny, fx, fy, fc, mp, ex, pl, rem, i;
    conv_result_t r;
    nx = one_if_zero(sh_cells_x);
    ny = one_if_zero(sh_cells_y);
    fx = one_if_zero(sh_fine_x);
    fy = one_if_zero(sh_fine_y);
    fc = one_if_zero(sh_fine_c);
    mp = one_if_zero(sh_members);
    r = '0;
    i = w.idx;
    ex = nx;
    pl = nx * ny;
    if (w.func == FN_FINE_SPLIT || w.func == FN_FINE_JOIN) begin
      ex = nx * fx;
      pl = ex * ny * fy;
    end
    case (w.func)
      FN_FINE_SPLIT, FN_COARSE_SPLIT: begin
        rem = i % pl;
        r.x = CW'(rem % ex);
        r.y = CW'(rem / ex);
        r.c = CW'(i / pl);
      end
      FN_FINE_JOIN, FN_COARSE_JOIN:
        r.idx = IW'(longint'(w.c) * pl + longint'(w.y) * ex + longint'(w.x));
      FN_FINE2COARSE: begin
        r.x = CW'(w.x / fx);
        r.y = CW'(w.y / fy);
        r.c = CW'(w.c / fc);
      end
      FN_MEMBER: r.idx = IW'(i / mp);
      default: ;
    endcase
    return r;
  endfunction

  // gaps come in bursts of idling and stretches of none
  logic busy_phase = 1'b1;
  function automatic int draw_wait();
    return busy_phase ? $urandom_range(0, 15) : 0;
  endfunction

  // driver
  int unsigned gap = 0;
  always @(posedge clk) begin
    conv_word_t w;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_results.push_back(convert_grid_word({in_func, in_linear_index,
                                                      in_coord_x, in_coord_y, in_coord_c}));
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (gap != 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_func <= w.func;
        in_linear_index <= w.idx;
        in_coord_x <= w.x;
        in_coord_y <= w.y;
        in_coord_c <= w.c;
        in_valid <= 1'b1;
        gap <= draw_wait();
        if ($urandom_range(0, 60) == 0) busy_phase <= ~busy_phase;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    conv_result_t e;
    int n;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word idx=%h x=%h y=%h c=%h", $time,
                   out_result_index, out_result_x, out_result_y, out_result_c);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_result_index !== e.idx) begin
            $display("%0t: result_index exp %h got %h", $time, e.idx, out_result_index);
            fail_count++;
          end
          if (out_result_x !== e.x) begin
            $display("%0t: result_x exp %h got %h", $time, e.x, out_result_x);
            fail_count++;
          end
          if (out_result_y !== e.y) begin
            $display("%0t: result_y exp %h got %h", $time, e.y, out_result_y);
            fail_count++;
          end
          if (out_result_c !== e.c) begin
            $display("%0t: result_c exp %h got %h", $time, e.c, out_result_c);
            fail_count++;
          end
        end
        n = draw_wait();
        stall_left <= n;
        out_stall <= (n != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("grid_index_coordinate_converter test failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t r, logic [CFG_DATA_W-1:0] d);
    cfg_index <= r;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (r)
      REG_COARSE_X: sh_cells_x = d[CNT_W-1:0];
      REG_COARSE_Y: sh_cells_y = d[CNT_W-1:0];
      REG_FINE_X:   sh_fine_x = d[FAC_W-1:0];
      REG_FINE_Y:   sh_fine_y = d[FAC_W-1:0];
      REG_FINE_C:   sh_fine_c = d[FAC_W-1:0];
      REG_MEMBERS:  sh_members = d[MEM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(int cx, int cy, int fx, int fy, int fc, int mp);
    write_reg(REG_COARSE_X, CFG_DATA_W'(cx));
    write_reg(REG_COARSE_Y, CFG_DATA_W'(cy));
    write_reg(REG_FINE_X, CFG_DATA_W'(fx));
    write_reg(REG_FINE_Y, CFG_DATA_W'(fy));
    write_reg(REG_FINE_C, CFG_DATA_W'(fc));
    write_reg(REG_MEMBERS, CFG_DATA_W'(mp));
  endtask

  task automatic add_word(func_t f, logic [IW-1:0] i, logic [CW-1:0] x,
                          logic [CW-1:0] y, logic [CW-1:0] c);
    pending_words.push_back({f, i, x, y, c});
  endtask

  // wait out the pipeline before touching the registers
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic random_words(int count);
    func_t f;
    logic [IW-1:0] i;
    logic [CW-1:0] x, y, c;
    for (int k = 0; k < count; k++) begin
      f = ($urandom_range(0, 9) == 0) ? func_t'($urandom_range(6, 7))
                                      : func_t'($urandom_range(0, 5));
      i = $urandom_range(0, 1) ? IW'($urandom) : IW'($urandom_range(0, 4095));
      x = $urandom_range(0, 1) ? CW'($urandom) : CW'($urandom_range(0, 63));
      y = $urandom_range(0, 1) ? CW'($urandom) : CW'($urandom_range(0, 63));
      c = $urandom_range(0, 1) ? CW'($urandom) : CW'($urandom_range(0, 15));
      add_word(f, i, x, y, c);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words on a small odd-shaped grid
    set_grid(7, 5, 3, 4, 2, 10);
    add_word(FN_FINE_SPLIT, 0, 0, 0, 0);
    add_word(FN_FINE_SPLIT, '1, 0, 0, 0);
    add_word(FN_FINE_SPLIT, 419, 0, 0, 0);
    add_word(FN_FINE_JOIN, 0, 0, 0, 0);
    add_word(FN_FINE_JOIN, 0, 20, 19, 1);
    add_word(FN_FINE_JOIN, 0, '1, '1, '1);
    add_word(FN_COARSE_SPLIT, 0, 0, 0, 0);
    add_word(FN_COARSE_SPLIT, '1, 0, 0, 0);
    add_word(FN_COARSE_JOIN, 0, 6, 4, 3);
    add_word(FN_COARSE_JOIN, 0, '1, '1, '1);
    add_word(FN_FINE2COARSE, 0, 0, 0, 0);
    add_word(FN_FINE2COARSE, 0, '1, '1, '1);
    add_word(FN_FINE2COARSE, 0, 2, 3, 1);
    add_word(FN_MEMBER, 0, 0, 0, 0);
    add_word(FN_MEMBER, '1, 0, 0, 0);
    add_word(FN_MEMBER, 9, 0, 0, 0);
    add_word(FN_SPARE_6, '1, '1, '1, '1);
    add_word(FN_SPARE_7, '1, '1, '1, '1);
    drain();

    // zero registers behave as one
    set_grid(0, 0, 0, 0, 0, 0);
    add_word(FN_FINE_SPLIT, '1, 0, 0, 0);
    add_word(FN_FINE2COARSE, 0, '1, 5, 9);
    add_word(FN_MEMBER, 12345, 0, 0, 0);
    random_words(WORDS_PER_PHASE);
    drain();

    set_grid(4096, 4096, 16, 16, 16, 65535);
    random_words(WORDS_PER_PHASE);
    drain();

    // all-ones data, truncated to each register's width
    set_grid(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_words(WORDS_PER_PHASE);
    drain();

    set_grid(1, 1, 1, 1, 1, 1);
    random_words(WORDS_PER_PHASE);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_grid($urandom_range(1, p == 0 ? 16 : 4096), $urandom_range(1, p == 0 ? 16 : 4096),
               $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
               $urandom_range(1, 65535));
      random_words(WORDS_PER_PHASE);
      drain();
    end

    if (fail_count == 0) begin
      $display("grid_index_coordinate_converter test passed");
    end else begin
      $display("grid_index_coordinate_converter test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gic_pkg.sv
rtl/gic_div_cell.sv
rtl/gic_div_chain.sv
rtl/grid_index_coordinate_converter.sv
verif/tb_top.sv
